// File: src/rrds_pkg.sv
// shared widths, register indexes and helpers for the daily runoff step
`default_nettype none
package rrds_pkg;

  localparam int unsigned LEVEL_WIDTH = 24;
  localparam int unsigned WIDE_W      = LEVEL_WIDTH + 4;
  localparam int unsigned REM_W       = LEVEL_WIDTH + 2;
  localparam int unsigned MUL_A_W     = LEVEL_WIDTH + 2;
  localparam int unsigned MUL_B_W     = LEVEL_WIDTH;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_W      = 12;
  localparam int unsigned DISCH_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 60;

  localparam logic [CFG_IDX_W-1:0] REG_SOIL_CAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ABS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_CAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECH_FRAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_LVL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARG_THR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCH_SC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECESSION = 3'd7;

  typedef logic [LEVEL_WIDTH-1:0] level_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // clamp a wide signed value into an unsigned level
  function automatic level_t clamp_lvl(input wide_t v);
    level_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0, {LEVEL_WIDTH{1'b1}}})) begin
      r = '1;
    end else begin
      r = v[LEVEL_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic wide_t widen(input level_t v);
    return $signed({4'b0, v});
  endfunction

endpackage
`default_nettype wire

// File: src/rrds_div_step.sv
// one restoring division step shared by both divisions
`default_nettype none
module rrds_div_step (
  input  logic [rrds_pkg::REM_W-1:0] rem_i,
  input  logic                       bit_i,
  input  logic [rrds_pkg::REM_W-1:0] divisor_i,
  output logic [rrds_pkg::REM_W-1:0] rem_o,
  output logic                       quo_bit_o
);
  import rrds_pkg::*;

  logic [REM_W:0] shifted;
  logic [REM_W:0] diff;

  assign shifted   = {rem_i, bit_i};
  assign diff      = shifted - {1'b0, divisor_i};
  assign quo_bit_o = (shifted >= {1'b0, divisor_i});
  assign rem_o     = quo_bit_o ? diff[REM_W-1:0] : shifted[REM_W-1:0];

endmodule
`default_nettype wire

// File: src/rainfall_runoff_daily_step_top.sv
// daily soil moisture accounting step: sequencer around one multiplier and one divide step
// a day word runs through up to 16 divide steps for the moisture ratio, 24 for the runoff
// quotient, ten multiplier passes, a range check and the update before its result is valid;
// a load word gives its result in the cycle after accept
// one word is in work at a time, the next one is taken the cycle after the result handshake
// reset clears the four stores, the registers to their defaults and the handshake state
`default_nettype none
module rainfall_runoff_daily_step_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // precipitation, evapotranspiration, marginal_evaporation, init_soil, init_surface,
  // init_marginal, init_ground
  input  logic [167:0]                       s_axis_tdata,
  // func
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // discharge, soil_level, surface_level, marginal_level, ground_level, surface_runoff,
  // real_evaporation, recharge, marginal_outflow, direct_flow, marginal_return,
  // fast_direct_flow
  output logic [295:0]                       m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rrds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrds_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rrds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TU, ST_SQ, ST_CHK, ST_ES, ST_ER, ST_R1, ST_R2, ST_MARG,
    ST_ED, ST_ED2, ST_ED3, ST_EB, ST_UPD, ST_Q, ST_OUT
  } state_e;

  state_e state_q;

  level_t cap_cfg_q, ai_q, fc_q, h_q, h1_q, ds_q;
  logic [15:0] rf_q;
  logic [CFG_DATA_W-1:0] kf_q;

  level_t soil_q, surf_q, mst_q, gnd_q;
  level_t p_q, ep_q, em_q;
  logic [16:0] tu_q;
  level_t es_q;
  logic [2*LEVEL_WIDTH-1:0] sq_q;
  logic [REM_W-1:0] rem_q;
  level_t dvd_q, quo_q;
  logic [4:0] cnt_q;
  wide_t er_q;
  logic [15:0] rf1_q;
  level_t rec_q, marg_q, ed_q, ed2_q, ed3_q, eb_q;
  logic [LEVEL_WIDTH+1:0] sum_q;

  logic [DISCH_W-1:0] o_dis_q;
  level_t o_soil_q, o_surf_q, o_mst_q, o_gnd_q, o_es_q, o_er_q, o_rec_q;
  level_t o_marg_q, o_ed_q, o_ed2_q, o_ed3_q;
  logic valid_q;

  level_t capv, e_val, s_fc, rest_v, lv_ed;
  logic   p_gt_ai;
  wide_t  den, d_v, ep_w, epd, above, t_v, cap_w, excess, soil_t;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [REM_W-1:0]   div_sor, rem_nx;
  logic               quo_bit;
  logic [PROD_W-9:0]  q_full;

  assign capv    = (cap_cfg_q == '0) ? level_t'(1) : cap_cfg_q;
  assign p_gt_ai = (p_q > ai_q);
  assign e_val   = p_q - ai_q;
  assign den     = widen(e_val) + widen(capv) - widen(soil_q);
  assign d_v     = widen(p_q) - widen(es_q);
  assign ep_w    = widen(ep_q);
  assign epd     = ep_w - d_v;
  assign s_fc    = soil_q - fc_q;
  assign rest_v  = surf_q - marg_q;
  assign lv_ed   = (rest_v < h_q) ? rest_v : h_q;
  assign above   = widen(surf_q) - widen(h_q) - widen(marg_q);
  assign cap_w   = widen(capv);
  assign t_v     = widen(soil_q) + widen(p_q) - widen(es_q) - er_q - widen(rec_q);
  assign excess  = (t_v > cap_w) ? t_v - cap_w : '0;
  assign soil_t  = (t_v < cap_w) ? t_v : cap_w;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ:   begin mul_a = MUL_A_W'(e_val); mul_b = e_val; end
      ST_ER:   begin mul_a = epd[MUL_A_W-1:0]; mul_b = MUL_B_W'(tu_q); end
      ST_R1:   begin mul_a = MUL_A_W'(rf_q); mul_b = MUL_B_W'(tu_q); end
      ST_R2:   begin mul_a = MUL_A_W'(rf1_q); mul_b = s_fc; end
      ST_MARG: begin mul_a = MUL_A_W'(surf_q - h1_q); mul_b = MUL_B_W'(kf_q[23:12]); end
      ST_ED:   begin mul_a = MUL_A_W'(lv_ed); mul_b = MUL_B_W'(kf_q[35:24]); end
      ST_ED2:  begin mul_a = MUL_A_W'(mst_q); mul_b = MUL_B_W'(kf_q[59:48]); end
      ST_ED3:  begin mul_a = above[MUL_A_W-1:0]; mul_b = MUL_B_W'(kf_q[47:36]); end
      ST_EB:   begin mul_a = MUL_A_W'(gnd_q); mul_b = MUL_B_W'(kf_q[11:0]); end
      ST_Q:    begin mul_a = sum_q; mul_b = ds_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign q_full = prod[PROD_W-1:8];

  assign div_sor = (state_q == ST_TU) ? REM_W'(capv) : den[REM_W-1:0];

  rrds_div_step u_div (
    .rem_i     (rem_q),
    .bit_i     (dvd_q[LEVEL_WIDTH-1]),
    .divisor_i (div_sor),
    .rem_o     (rem_nx),
    .quo_bit_o (quo_bit)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {o_ed3_q, o_ed2_q, o_ed_q, o_marg_q, o_rec_q, o_er_q, o_es_q,
                          o_gnd_q, o_mst_q, o_surf_q, o_soil_q, o_dis_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= level_t'(256000);
      ai_q      <= level_t'(1280);
      fc_q      <= level_t'(128000);
      rf_q      <= '0;
      h_q       <= level_t'(51200);
      h1_q      <= level_t'(51200);
      ds_q      <= level_t'(256);
      kf_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SOIL_CAP:  cap_cfg_q <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_INIT_ABS:  ai_q      <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_FIELD_CAP: fc_q      <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_RECH_FRAC: rf_q      <= cfg_data_i[15:0];
        REG_SPLIT_LVL: h_q       <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_MARG_THR:  h1_q      <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_DISCH_SC:  ds_q      <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_RECESSION: kf_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      soil_q  <= '0;
      surf_q  <= '0;
      mst_q   <= '0;
      gnd_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              soil_q   <= s_axis_tdata[95:72];
              surf_q   <= s_axis_tdata[119:96];
              mst_q    <= s_axis_tdata[143:120];
              gnd_q    <= s_axis_tdata[167:144];
              o_soil_q <= s_axis_tdata[95:72];
              o_surf_q <= s_axis_tdata[119:96];
              o_mst_q  <= s_axis_tdata[143:120];
              o_gnd_q  <= s_axis_tdata[167:144];
              o_dis_q  <= '0;
              o_es_q   <= '0;
              o_er_q   <= '0;
              o_rec_q  <= '0;
              o_marg_q <= '0;
              o_ed_q   <= '0;
              o_ed2_q  <= '0;
              o_ed3_q  <= '0;
              valid_q  <= 1'b1;
              state_q  <= ST_OUT;
            end else begin
              p_q   <= s_axis_tdata[23:0];
              ep_q  <= s_axis_tdata[47:24];
              em_q  <= s_axis_tdata[71:48];
              rem_q <= REM_W'(soil_q);
              dvd_q <= '0;
              quo_q <= '0;
              cnt_q <= '0;
              if (soil_q >= capv) begin
                tu_q    <= 17'h10000;
                state_q <= ST_SQ;
              end else begin
                state_q <= ST_TU;
              end
            end
          end
        end
        ST_TU: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[LEVEL_WIDTH-2:0], quo_bit};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) begin
            tu_q    <= {1'b0, quo_q[14:0], quo_bit};
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_q <= prod[2*LEVEL_WIDTH-1:0];
          if (!p_gt_ai) begin
            es_q    <= '0;
            state_q <= ST_ER;
          end else if (den <= 0) begin
            es_q    <= e_val;
            state_q <= ST_ER;
          end else begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          rem_q <= REM_W'(sq_q[2*LEVEL_WIDTH-1:LEVEL_WIDTH]);
          dvd_q <= sq_q[LEVEL_WIDTH-1:0];
          cnt_q <= '0;
          // quotient would not fit a level
          if (REM_W'(sq_q[2*LEVEL_WIDTH-1:LEVEL_WIDTH]) >= den[REM_W-1:0]) begin
            es_q    <= '1;
            state_q <= ST_ER;
          end else begin
            state_q <= ST_ES;
          end
        end
        ST_ES: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[LEVEL_WIDTH-2:0], 1'b0};
          quo_q <= {quo_q[LEVEL_WIDTH-2:0], quo_bit};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(LEVEL_WIDTH - 1)) begin
            es_q    <= {quo_q[LEVEL_WIDTH-2:0], quo_bit};
            state_q <= ST_ER;
          end
        end
        ST_ER: begin
          if (d_v > ep_w) begin
            er_q <= ep_w;
          end else begin
            er_q <= d_v + $signed({1'b0, prod[42:16]});
          end
          state_q <= ST_R1;
        end
        ST_R1: begin
          rf1_q   <= prod[31:16];
          state_q <= ST_R2;
        end
        ST_R2: begin
          rec_q   <= (soil_q > fc_q) ? prod[LEVEL_WIDTH+15:16] : '0;
          state_q <= ST_MARG;
        end
        ST_MARG: begin
          marg_q  <= (surf_q > h1_q) ? prod[LEVEL_WIDTH+FRAC_W-1:FRAC_W] : '0;
          state_q <= ST_ED;
        end
        ST_ED: begin
          ed_q    <= prod[LEVEL_WIDTH+FRAC_W-1:FRAC_W];
          state_q <= ST_ED2;
        end
        ST_ED2: begin
          ed2_q   <= prod[LEVEL_WIDTH+FRAC_W-1:FRAC_W];
          state_q <= ST_ED3;
        end
        ST_ED3: begin
          ed3_q   <= (above > 0) ? prod[LEVEL_WIDTH+FRAC_W-1:FRAC_W] : '0;
          state_q <= ST_EB;
        end
        ST_EB: begin
          eb_q    <= prod[LEVEL_WIDTH+FRAC_W-1:FRAC_W];
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          soil_q   <= clamp_lvl(soil_t);
          gnd_q    <= clamp_lvl(widen(gnd_q) + widen(rec_q) - widen(eb_q));
          surf_q   <= clamp_lvl(widen(surf_q) + widen(es_q) - widen(marg_q) - widen(ed_q)
                                - widen(ed3_q) + excess);
          mst_q    <= clamp_lvl(widen(mst_q) + widen(marg_q) - widen(ed2_q) - widen(em_q));
          o_soil_q <= clamp_lvl(soil_t);
          o_gnd_q  <= clamp_lvl(widen(gnd_q) + widen(rec_q) - widen(eb_q));
          o_surf_q <= clamp_lvl(widen(surf_q) + widen(es_q) - widen(marg_q) - widen(ed_q)
                                - widen(ed3_q) + excess);
          o_mst_q  <= clamp_lvl(widen(mst_q) + widen(marg_q) - widen(ed2_q) - widen(em_q));
          o_es_q   <= es_q;
          o_er_q   <= clamp_lvl(er_q);
          o_rec_q  <= rec_q;
          o_marg_q <= marg_q;
          o_ed_q   <= ed_q;
          o_ed2_q  <= ed2_q;
          o_ed3_q  <= ed3_q;
          sum_q    <= (LEVEL_WIDTH+2)'(ed_q) + (LEVEL_WIDTH+2)'(ed2_q)
                    + (LEVEL_WIDTH+2)'(ed3_q) + (LEVEL_WIDTH+2)'(eb_q);
          state_q  <= ST_Q;
        end
        ST_Q: begin
          o_dis_q <= (q_full > (PROD_W-8)'({DISCH_W{1'b1}})) ? '1 : q_full[DISCH_W-1:0];
          valid_q <= 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            valid_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
